// File: sv/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

	// Field widths
	localparam int ReqW   = 2;
	localparam int SampW  = 12;
	localparam int SpeedW = 10;
	localparam int TickW  = 16;
	localparam int StateW = 3;
	localparam int DirW   = 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 12;

	// Reverse drive level
	localparam logic [SpeedW-1:0] BACK_SPEED = SpeedW'(600);

	// Sequencer state codes as shown on the result stream
	localparam logic [StateW-1:0] FSM_IDLE   = 3'd0;
	localparam logic [StateW-1:0] FSM_STOP   = 3'd1;
	localparam logic [StateW-1:0] FSM_BACK   = 3'd2;
	localparam logic [StateW-1:0] FSM_ONE    = 3'd3;
	localparam logic [StateW-1:0] FSM_TWO    = 3'd4;
	localparam logic [StateW-1:0] FSM_SETTLE = 3'd5;

	// Turn request codes
	localparam logic [ReqW-1:0] REQ_NONE  = 2'd0;
	localparam logic [ReqW-1:0] REQ_CROSS = 2'd1;
	localparam logic [ReqW-1:0] REQ_LEFT  = 2'd2;
	localparam logic [ReqW-1:0] REQ_RIGHT = 2'd3;

	// Turn direction codes
	localparam logic [DirW-1:0] DIR_NONE  = 2'd0;
	localparam logic [DirW-1:0] DIR_LEFT  = 2'd1;
	localparam logic [DirW-1:0] DIR_RIGHT = 2'd2;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_STOP_TICKS   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_BACK_TICKS   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MIN_RIGHT    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_MIN_LEFT     = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_LEFT_THR     = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_RIGHT_THR    = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_TURN_SPEED   = 3'd7;

	// Input item, last declared field in the lowest bits
	typedef struct packed {
		logic [5:0]       pad;
		logic [SampW-1:0] right_sample;
		logic [SampW-1:0] left_sample;
		logic [ReqW-1:0]  turn_request;
	} item_t;

	// Result item, last declared field in the lowest bits
	typedef struct packed {
		logic              pad;
		logic [DirW-1:0]   turn_direction;
		logic [TickW-1:0]  elapsed_ticks;
		logic              clear_request;
		logic [SpeedW-1:0] right_rev_speed;
		logic [SpeedW-1:0] right_fwd_speed;
		logic [SpeedW-1:0] left_rev_speed;
		logic [SpeedW-1:0] left_fwd_speed;
		logic              motor_write;
		logic [StateW-1:0] fsm_state;
	} result_t;

	localparam int ItemW   = $bits(item_t);
	localparam int ResultW = $bits(result_t);

endpackage

// File: sv/timed_turn_sequencer.sv
`timescale 1ns / 1ps

// Timed turn sequencer. Each stream transaction in is one 10 ms tick carrying a
// turn request and the two line-sensor samples; each produces exactly one result
// transaction with the sequencer state, the held wheel command, a motor_write
// pulse, a clear_request pulse, the saturating tick count and the turn direction.
// A transaction is registered on entry; the step is computed from that register
// and lands in the output register, so one tick is taken every cycle while the
// output is not stalled; the output register lets a new tick enter while a result
// waits. Configuration writes are taken every cycle and are meant for idle times.
module timed_turn_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input ticks: turn_request[1:0], left_sample[13:2], right_sample[25:14]
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [tts_pkg::ItemW-1:0]     s_axis_tdata,
	// Results: fsm_state[2:0], motor_write[3], left_fwd_speed[13:4],
	// left_rev_speed[23:14], right_fwd_speed[33:24], right_rev_speed[43:34],
	// clear_request[44], elapsed_ticks[60:45], turn_direction[62:61]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [tts_pkg::ResultW-1:0]   m_axis_tdata,
	// Configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tts_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [tts_pkg::CfgDataW-1:0]  cfg_data
);

	typedef enum logic [tts_pkg::StateW-1:0] {
		ST_IDLE   = tts_pkg::FSM_IDLE,
		ST_STOP   = tts_pkg::FSM_STOP,
		ST_BACK   = tts_pkg::FSM_BACK,
		ST_ONE    = tts_pkg::FSM_ONE,
		ST_TWO    = tts_pkg::FSM_TWO,
		ST_SETTLE = tts_pkg::FSM_SETTLE
	} state_t;

	typedef struct packed {
		logic [tts_pkg::SpeedW-1:0] lf;
		logic [tts_pkg::SpeedW-1:0] lr;
		logic [tts_pkg::SpeedW-1:0] rf;
		logic [tts_pkg::SpeedW-1:0] rr;
	} wheel_t;

	// Configuration registers
	logic [7:0]                   stop_ticks_q, back_ticks_q, settle_ticks_q;
	logic [7:0]                   min_right_q, min_left_q;
	logic [tts_pkg::SampW-1:0]    left_thr_q, right_thr_q;
	logic [tts_pkg::SpeedW-1:0]   turn_speed_q;

	// Sequencer state
	state_t                       state_q, state_nx;
	logic [tts_pkg::TickW-1:0]    tick_q, tick_nx, tick_inc;
	logic [tts_pkg::DirW-1:0]     dir_q, dir_nx;
	wheel_t                       wheel_q, wheel_nx;
	logic                         wr_nx, clr_nx;

	// Pipeline
	logic                         valid_s1, valid_s2;
	tts_pkg::item_t               item_s1;
	tts_pkg::result_t             res_s2;
	logic                         advance;

	wheel_t                       cmd_stop, cmd_back, cmd_right, cmd_left;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_ticks_q   <= 8'd10;
			back_ticks_q   <= 8'd19;
			settle_ticks_q <= 8'd10;
			min_right_q    <= 8'd25;
			min_left_q     <= 8'd15;
			left_thr_q     <= 12'd2048;
			right_thr_q    <= 12'd2048;
			turn_speed_q   <= 10'd600;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tts_pkg::CFG_STOP_TICKS:   stop_ticks_q   <= cfg_data[7:0];
				tts_pkg::CFG_BACK_TICKS:   back_ticks_q   <= cfg_data[7:0];
				tts_pkg::CFG_SETTLE_TICKS: settle_ticks_q <= cfg_data[7:0];
				tts_pkg::CFG_MIN_RIGHT:    min_right_q    <= cfg_data[7:0];
				tts_pkg::CFG_MIN_LEFT:     min_left_q     <= cfg_data[7:0];
				tts_pkg::CFG_LEFT_THR:     left_thr_q     <= cfg_data;
				tts_pkg::CFG_RIGHT_THR:    right_thr_q    <= cfg_data;
				tts_pkg::CFG_TURN_SPEED:   turn_speed_q   <= cfg_data[tts_pkg::SpeedW-1:0];
			endcase
		end
	end

	// Wheel commands
	always_comb begin
		cmd_stop  = '0;
		cmd_back  = '{lf: '0, lr: tts_pkg::BACK_SPEED, rf: '0, rr: tts_pkg::BACK_SPEED};
		cmd_right = '{lf: turn_speed_q, lr: '0, rf: '0, rr: turn_speed_q};
		cmd_left  = '{lf: '0, lr: turn_speed_q, rf: turn_speed_q, rr: '0};
	end

	// Saturating tick increment
	assign tick_inc = (&tick_q) ? tick_q : tick_q + 1'b1;

	// Step the sequencer for the registered tick
	always_comb begin
		state_nx = state_q;
		tick_nx  = tick_q;
		dir_nx   = dir_q;
		wheel_nx = wheel_q;
		wr_nx    = 1'b0;
		clr_nx   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_s1.turn_request != tts_pkg::REQ_NONE) begin
					dir_nx   = (item_s1.turn_request == tts_pkg::REQ_LEFT) ?
						tts_pkg::DIR_LEFT : tts_pkg::DIR_RIGHT;
					wheel_nx = cmd_stop;
					wr_nx    = 1'b1;
					tick_nx  = '0;
					state_nx = ST_STOP;
				end
			end
			ST_STOP: begin
				tick_nx = tick_inc;
				if (tick_inc >= {8'd0, stop_ticks_q}) begin
					wheel_nx = cmd_back;
					wr_nx    = 1'b1;
					tick_nx  = '0;
					state_nx = ST_BACK;
				end
			end
			ST_BACK: begin
				tick_nx = tick_inc;
				if (tick_inc >= {8'd0, back_ticks_q}) begin
					wheel_nx = cmd_stop;
					wr_nx    = 1'b1;
					tick_nx  = '0;
					state_nx = ST_ONE;
				end
			end
			ST_ONE: begin
				tick_nx = tick_inc;
				if (dir_q == tts_pkg::DIR_RIGHT) begin
					wheel_nx = cmd_right;
					wr_nx    = 1'b1;
					if (item_s1.left_sample >= left_thr_q &&
						tick_inc >= {8'd0, min_right_q}) begin
						tick_nx  = '0;
						state_nx = ST_TWO;
					end
				end else if (dir_q == tts_pkg::DIR_LEFT) begin
					wheel_nx = cmd_left;
					wr_nx    = 1'b1;
					if (item_s1.right_sample >= right_thr_q &&
						tick_inc >= {8'd0, min_left_q}) begin
						tick_nx  = '0;
						state_nx = ST_TWO;
					end
				end
			end
			ST_TWO: begin
				if (dir_q == tts_pkg::DIR_RIGHT) begin
					wheel_nx = cmd_right;
					wr_nx    = 1'b1;
					if (item_s1.right_sample < right_thr_q) begin
						wheel_nx = cmd_stop;
						tick_nx  = '0;
						state_nx = ST_SETTLE;
					end
				end else if (dir_q == tts_pkg::DIR_LEFT) begin
					wheel_nx = cmd_left;
					wr_nx    = 1'b1;
					if (item_s1.left_sample < left_thr_q) begin
						wheel_nx = cmd_stop;
						tick_nx  = '0;
						state_nx = ST_SETTLE;
					end
				end
			end
			ST_SETTLE: begin
				tick_nx = tick_inc;
				if (tick_inc >= {8'd0, settle_ticks_q}) begin
					clr_nx   = 1'b1;
					state_nx = ST_IDLE;
					tick_nx  = '0;
					dir_nx   = tts_pkg::DIR_NONE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
				tick_nx  = '0;
				dir_nx   = tts_pkg::DIR_NONE;
			end
		endcase
	end

	// Hold state, input register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tick_q   <= '0;
			dir_q    <= tts_pkg::DIR_NONE;
			wheel_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nx;
				tick_q   <= tick_nx;
				dir_q    <= dir_nx;
				wheel_q  <= wheel_nx;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= s_axis_tdata;
		end
		if (advance) begin
			res_s2.pad             <= 1'b0;
			res_s2.turn_direction  <= dir_nx;
			res_s2.elapsed_ticks   <= tick_nx;
			res_s2.clear_request   <= clr_nx;
			res_s2.right_rev_speed <= wheel_nx.rr;
			res_s2.right_fwd_speed <= wheel_nx.rf;
			res_s2.left_rev_speed  <= wheel_nx.lr;
			res_s2.left_fwd_speed  <= wheel_nx.lf;
			res_s2.motor_write     <= wr_nx;
			res_s2.fsm_state       <= state_nx;
		end
	end

endmodule

// File: sv/tts_checker.sv
`timescale 1ns / 1ps

module tts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [tts_pkg::ResultW-1:0]   m_axis_tdata
);

	tts_pkg::result_t res;

	assign res = m_axis_tdata;

	// Stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Idle never issues a wheel command
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.fsm_state == tts_pkg::FSM_IDLE |-> !res.motor_write)
		else $error("motor write while idle");

	// Clear pulse comes with the return to idle
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.clear_request |->
			res.fsm_state == tts_pkg::FSM_IDLE && res.elapsed_ticks == '0 &&
			res.turn_direction == tts_pkg::DIR_NONE)
		else $error("clear request outside the end of settling");

	// Phase two does not count ticks
	a_two_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.fsm_state == tts_pkg::FSM_TWO |-> res.elapsed_ticks == '0)
		else $error("tick count in phase two");

endmodule

bind timed_turn_sequencer tts_checker u_tts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/timed_turn_sequencer_tb.sv
`timescale 1ns / 1ps

module timed_turn_sequencer_tb;

	// Cycles with no transaction on any channel before the run is declared hung
	localparam int WatchdogLimit = 1000;
	// Ticks per random phase
	localparam int PhaseTicks = 70;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [tts_pkg::ItemW-1:0]    s_axis_tdata = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [tts_pkg::ResultW-1:0]  m_axis_tdata;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [tts_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [tts_pkg::CfgDataW-1:0] cfg_data = '0;

	timed_turn_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// Ticks waiting for the driver and predicted results waiting for the monitor
	tts_pkg::item_t   pending_ticks[$];
	tts_pkg::result_t expected_steps[$];
	int unsigned      queued_total = 0;
	int unsigned      fail_count = 0;
	int unsigned      gap_left = 0;
	int unsigned      stall_left = 0;
	int unsigned      quiet_cycles = 0;
	bit               steady_flow = 1'b0;
	tts_pkg::result_t seen_step;
	tts_pkg::result_t due_step;

	// Mirror of the sequencer: registers, state, counter, direction, wheel command
	logic [tts_pkg::CfgDataW-1:0] reg_file [8];
	logic [tts_pkg::StateW-1:0]   seq_state;
	logic [tts_pkg::TickW-1:0]    seq_ticks;
	logic [tts_pkg::DirW-1:0]     seq_dir;
	logic [tts_pkg::SpeedW-1:0]   wheel_lf, wheel_lr, wheel_rf, wheel_rr;

	function automatic void reset_mirror();
		reg_file[tts_pkg::CFG_STOP_TICKS]   = 12'd10;
		reg_file[tts_pkg::CFG_BACK_TICKS]   = 12'd19;
		reg_file[tts_pkg::CFG_SETTLE_TICKS] = 12'd10;
		reg_file[tts_pkg::CFG_MIN_RIGHT]    = 12'd25;
		reg_file[tts_pkg::CFG_MIN_LEFT]     = 12'd15;
		reg_file[tts_pkg::CFG_LEFT_THR]     = 12'd2048;
		reg_file[tts_pkg::CFG_RIGHT_THR]    = 12'd2048;
		reg_file[tts_pkg::CFG_TURN_SPEED]   = 12'd600;
		seq_state = tts_pkg::FSM_IDLE;
		seq_ticks = '0;
		seq_dir   = tts_pkg::DIR_NONE;
		wheel_lf  = '0;
		wheel_lr  = '0;
		wheel_rf  = '0;
		wheel_rr  = '0;
	endfunction

	function automatic void set_wheels(input logic [tts_pkg::SpeedW-1:0] lf,
			input logic [tts_pkg::SpeedW-1:0] lr, input logic [tts_pkg::SpeedW-1:0] rf,
			input logic [tts_pkg::SpeedW-1:0] rr);
		wheel_lf = lf;
		wheel_lr = lr;
		wheel_rf = rf;
		wheel_rr = rr;
	endfunction

	// Count one tick, holding at the top instead of wrapping
	function automatic void bump_ticks();
		if (seq_ticks != '1)
			seq_ticks = seq_ticks + 1'b1;
	endfunction

	// Step the mirror by one tick and return the result it should produce
	function automatic tts_pkg::result_t advance_sequencer(input tts_pkg::item_t tick);
		tts_pkg::result_t           res;
		logic [tts_pkg::SpeedW-1:0] spd;
		logic                       wr;
		logic                       clr;
		spd = reg_file[tts_pkg::CFG_TURN_SPEED][tts_pkg::SpeedW-1:0];
		wr  = 1'b0;
		clr = 1'b0;
		case (seq_state)
			tts_pkg::FSM_IDLE: begin
				if (tick.turn_request != tts_pkg::REQ_NONE) begin
					seq_dir = (tick.turn_request == tts_pkg::REQ_LEFT) ?
						tts_pkg::DIR_LEFT : tts_pkg::DIR_RIGHT;
					set_wheels('0, '0, '0, '0);
					wr = 1'b1;
					seq_ticks = '0;
					seq_state = tts_pkg::FSM_STOP;
				end
			end
			tts_pkg::FSM_STOP: begin
				bump_ticks();
				if (seq_ticks >= reg_file[tts_pkg::CFG_STOP_TICKS][7:0]) begin
					set_wheels('0, tts_pkg::BACK_SPEED, '0, tts_pkg::BACK_SPEED);
					wr = 1'b1;
					seq_ticks = '0;
					seq_state = tts_pkg::FSM_BACK;
				end
			end
			tts_pkg::FSM_BACK: begin
				bump_ticks();
				if (seq_ticks >= reg_file[tts_pkg::CFG_BACK_TICKS][7:0]) begin
					set_wheels('0, '0, '0, '0);
					wr = 1'b1;
					seq_ticks = '0;
					seq_state = tts_pkg::FSM_ONE;
				end
			end
			tts_pkg::FSM_ONE: begin
				// leading sensor is the one on the far side of the turn
				bump_ticks();
				if (seq_dir == tts_pkg::DIR_RIGHT) begin
					set_wheels(spd, '0, '0, spd);
					wr = 1'b1;
					if (tick.left_sample >= reg_file[tts_pkg::CFG_LEFT_THR] &&
							seq_ticks >= reg_file[tts_pkg::CFG_MIN_RIGHT][7:0]) begin
						seq_ticks = '0;
						seq_state = tts_pkg::FSM_TWO;
					end
				end else if (seq_dir == tts_pkg::DIR_LEFT) begin
					set_wheels('0, spd, spd, '0);
					wr = 1'b1;
					if (tick.right_sample >= reg_file[tts_pkg::CFG_RIGHT_THR] &&
							seq_ticks >= reg_file[tts_pkg::CFG_MIN_LEFT][7:0]) begin
						seq_ticks = '0;
						seq_state = tts_pkg::FSM_TWO;
					end
				end
			end
			tts_pkg::FSM_TWO: begin
				// no counting here; stop as soon as the trailing sensor finds the line
				if (seq_dir == tts_pkg::DIR_RIGHT) begin
					set_wheels(spd, '0, '0, spd);
					wr = 1'b1;
					if (tick.right_sample < reg_file[tts_pkg::CFG_RIGHT_THR]) begin
						set_wheels('0, '0, '0, '0);
						seq_ticks = '0;
						seq_state = tts_pkg::FSM_SETTLE;
					end
				end else if (seq_dir == tts_pkg::DIR_LEFT) begin
					set_wheels('0, spd, spd, '0);
					wr = 1'b1;
					if (tick.left_sample < reg_file[tts_pkg::CFG_LEFT_THR]) begin
						set_wheels('0, '0, '0, '0);
						seq_ticks = '0;
						seq_state = tts_pkg::FSM_SETTLE;
					end
				end
			end
			tts_pkg::FSM_SETTLE: begin
				bump_ticks();
				if (seq_ticks >= reg_file[tts_pkg::CFG_SETTLE_TICKS][7:0]) begin
					clr = 1'b1;
					seq_state = tts_pkg::FSM_IDLE;
					seq_ticks = '0;
					seq_dir = tts_pkg::DIR_NONE;
				end
			end
			default: begin
				seq_state = tts_pkg::FSM_IDLE;
				seq_ticks = '0;
				seq_dir = tts_pkg::DIR_NONE;
			end
		endcase
		res = '0;
		res.fsm_state       = seq_state;
		res.motor_write     = wr;
		res.left_fwd_speed  = wheel_lf;
		res.left_rev_speed  = wheel_lr;
		res.right_fwd_speed = wheel_rf;
		res.right_rev_speed = wheel_rr;
		res.clear_request   = clr;
		res.elapsed_ticks   = seq_ticks;
		res.turn_direction  = seq_dir;
		return res;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [tts_pkg::SampW-1:0] rnd_sample();
		return tts_pkg::SampW'($urandom_range(0, 4095));
	endfunction

	// A level on the line is below the threshold; with a zero threshold none is
	function automatic logic [tts_pkg::SampW-1:0] on_line(
			input logic [tts_pkg::SampW-1:0] thr);
		return (thr == 0) ? '0 : tts_pkg::SampW'($urandom_range(0, thr - 1));
	endfunction

	function automatic logic [tts_pkg::SampW-1:0] off_line(
			input logic [tts_pkg::SampW-1:0] thr);
		return tts_pkg::SampW'($urandom_range(thr, 4095));
	endfunction

	// A threshold of zero still leaves its state after one tick
	function automatic int unsigned ticks_to_leave(input int unsigned limit);
		return (limit == 0) ? 1 : limit;
	endfunction

	function automatic void push_tick(input logic [tts_pkg::ReqW-1:0] req,
			input logic [tts_pkg::SampW-1:0] ls, input logic [tts_pkg::SampW-1:0] rs);
		tts_pkg::item_t it;
		it = '0;
		it.turn_request = req;
		it.left_sample  = ls;
		it.right_sample = rs;
		pending_ticks.push_back(it);
		queued_total++;
	endfunction

	function automatic void push_noise();
		push_tick(tts_pkg::ReqW'($urandom_range(0, 3)), rnd_sample(), rnd_sample());
	endfunction

	// Tick with one sensor set and everything else random
	function automatic void push_side(input bit left_side,
			input logic [tts_pkg::SampW-1:0] level);
		if (left_side)
			push_tick(tts_pkg::ReqW'($urandom_range(0, 3)), level, rnd_sample());
		else
			push_tick(tts_pkg::ReqW'($urandom_range(0, 3)), rnd_sample(), level);
	endfunction

	// Queue one complete turn, timed against the current register values
	task automatic queue_turn(input logic [tts_pkg::ReqW-1:0] req, input int unsigned hold);
		bit                        go_right;
		logic [tts_pkg::SampW-1:0] lead_thr;
		logic [tts_pkg::SampW-1:0] trail_thr;
		int unsigned               min_t;
		go_right  = (req != tts_pkg::REQ_LEFT);
		lead_thr  = go_right ? reg_file[tts_pkg::CFG_LEFT_THR] :
			reg_file[tts_pkg::CFG_RIGHT_THR];
		trail_thr = go_right ? reg_file[tts_pkg::CFG_RIGHT_THR] :
			reg_file[tts_pkg::CFG_LEFT_THR];
		min_t     = go_right ? reg_file[tts_pkg::CFG_MIN_RIGHT][7:0] :
			reg_file[tts_pkg::CFG_MIN_LEFT][7:0];
		push_tick(req, rnd_sample(), rnd_sample());
		// stop and reverse ignore the tick content
		repeat (ticks_to_leave(reg_file[tts_pkg::CFG_STOP_TICKS][7:0]) +
				ticks_to_leave(reg_file[tts_pkg::CFG_BACK_TICKS][7:0]))
			push_noise();
		// phase one: below the minimum nothing matters, then hold the leading sensor on
		repeat (ticks_to_leave(min_t) - 1)
			push_noise();
		repeat (hold)
			push_side(go_right, on_line(lead_thr));
		push_side(go_right, off_line(lead_thr));
		// phase two: trailing sensor off the line a while, then back on
		repeat ($urandom_range(0, 3))
			push_side(!go_right, off_line(trail_thr));
		push_side(!go_right, on_line(trail_thr));
		repeat (ticks_to_leave(reg_file[tts_pkg::CFG_SETTLE_TICKS][7:0]))
			push_noise();
		repeat ($urandom_range(0, 2))
			push_tick(tts_pkg::REQ_NONE, rnd_sample(), rnd_sample());
	endtask

	task automatic write_reg(input logic [tts_pkg::CfgIdxW-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= tts_pkg::CfgDataW'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_file[idx] = tts_pkg::CfgDataW'(value);
	endtask

	task automatic load_config(input int unsigned stop_t, input int unsigned back_t,
			input int unsigned settle_t, input int unsigned min_r, input int unsigned min_l,
			input int unsigned thr_l, input int unsigned thr_r, input int unsigned spd);
		write_reg(tts_pkg::CFG_STOP_TICKS, stop_t);
		write_reg(tts_pkg::CFG_BACK_TICKS, back_t);
		write_reg(tts_pkg::CFG_SETTLE_TICKS, settle_t);
		write_reg(tts_pkg::CFG_MIN_RIGHT, min_r);
		write_reg(tts_pkg::CFG_MIN_LEFT, min_l);
		write_reg(tts_pkg::CFG_LEFT_THR, thr_l);
		write_reg(tts_pkg::CFG_RIGHT_THR, thr_r);
		write_reg(tts_pkg::CFG_TURN_SPEED, spd);
	endtask

	// Hold until every queued tick is sent and every result is back, then let the pipe empty
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || s_axis_tvalid || expected_steps.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Driver: predict each accepted tick, then present the next one after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_steps.push_back(advance_sequencer(tts_pkg::item_t'(s_axis_tdata)));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					s_axis_tdata  <= pending_ticks.pop_front();
					s_axis_tvalid <= 1'b1;
					gap_left = steady_flow ? 0 : idle_len();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transaction with the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_step = tts_pkg::result_t'(m_axis_tdata);
				if (expected_steps.size() == 0) begin
					$error("result with no prediction pending: %h", m_axis_tdata);
					fail_count++;
				end else begin
					due_step = expected_steps.pop_front();
					check_field("fsm_state", due_step.fsm_state, seen_step.fsm_state);
					check_field("motor_write", due_step.motor_write, seen_step.motor_write);
					check_field("left_fwd_speed", due_step.left_fwd_speed,
						seen_step.left_fwd_speed);
					check_field("left_rev_speed", due_step.left_rev_speed,
						seen_step.left_rev_speed);
					check_field("right_fwd_speed", due_step.right_fwd_speed,
						seen_step.right_fwd_speed);
					check_field("right_rev_speed", due_step.right_rev_speed,
						seen_step.right_rev_speed);
					check_field("clear_request", due_step.clear_request,
						seen_step.clear_request);
					check_field("elapsed_ticks", due_step.elapsed_ticks,
						seen_step.elapsed_ticks);
					check_field("turn_direction", due_step.turn_direction,
						seen_step.turn_direction);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				stall_left = steady_flow ? 0 : idle_len();
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: give up when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WatchdogLimit) begin
				$display("timed_turn_sequencer_tb failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned phase_goal;
		reset_mirror();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: short timings so each turn fits in a handful of ticks
		load_config(1, 1, 1, 2, 1, 2048, 2048, 1023);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd4095, 12'd4095);
		push_tick(tts_pkg::REQ_CROSS, 12'd100, 12'd100);
		push_tick(tts_pkg::REQ_LEFT, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd4095, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd4095, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd4095);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_RIGHT, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_LEFT, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd4095, 12'd2047);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd2048);
		push_tick(tts_pkg::REQ_NONE, 12'd2048, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd2047, 12'd4095);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_RIGHT, 12'd4095, 12'd4095);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd4095);
		push_tick(tts_pkg::REQ_NONE, 12'd4095, 12'd4095);
		push_tick(tts_pkg::REQ_NONE, 12'd4095, 12'd0);
		push_tick(tts_pkg::REQ_NONE, 12'd0, 12'd0);
		wait_drained();

		// Hold phase one for a long stretch, no idling on either side
		load_config(0, 0, 3, 6, 6, 4095, 4095, $urandom_range(0, 1023));
		steady_flow = 1'b1;
		queue_turn(tts_pkg::REQ_RIGHT, 40);
		queue_turn(tts_pkg::REQ_LEFT, 2);
		wait_drained();
		steady_flow = 1'b0;

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				1: load_config(0, 0, 0, 0, 0, 4095, 4095, 1023);
				2: load_config($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
					$urandom_range(0, 4), $urandom_range(0, 4), 0, 4095, 0);
				4: load_config(255, 255, $urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom_range(1, 4095), $urandom_range(1, 4095),
					$urandom_range(0, 1023));
				default: load_config($urandom_range(0, 5), $urandom_range(0, 5),
					$urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
					$urandom_range(1, 4095), $urandom_range(1, 4095),
					$urandom_range(0, 1023));
			endcase
			phase_goal = queued_total + PhaseTicks;
			while (queued_total < phase_goal) begin
				if ($urandom_range(0, 99) < 20)
					push_noise();
				else
					queue_turn(tts_pkg::ReqW'($urandom_range(1, 3)), $urandom_range(0, 3));
			end
			wait_drained();
		end

		if (expected_steps.size() != 0) begin
			$error("%0d predicted results never arrived", expected_steps.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("timed_turn_sequencer_tb passed");
		else
			$display("timed_turn_sequencer_tb failed");
		$finish;
	end

endmodule

// File: files.f
sv/tts_pkg.sv
sv/timed_turn_sequencer.sv
sv/tts_checker.sv
tb/timed_turn_sequencer_tb.sv
